>>> sv/token_route_table_unit_assert.svh
// Assertion macros used by the token route table sequencer (trt_ctrl).
`ifndef TOKEN_ROUTE_TABLE_UNIT_ASSERT_SVH
`define TOKEN_ROUTE_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token route table: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token route table: next-cycle check failed");

`endif

>>> sv/trt_pkg.sv
// Shared types and constants of the token route table.
package trt_pkg;

  localparam int ROUTE_ENTRIES = 32;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int TOKEN_W       = 64;
  localparam int LINK_W        = 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_LOCAL    = 3'd3,
    ST_FORWARD  = 3'd4,
    ST_NOROUTE  = 3'd5
  } status_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] tok;
    logic [LINK_W-1:0]  link;
    logic               loc;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic              vld;
    status_t           status;
    logic [LINK_W-1:0] link;
  } res_t;

endpackage

>>> sv/token_route_table_unit.sv
// Flow: a lookup or a failed or plain insert scans every entry once, decides, then registers its result
//   onto out_strobe; an inserted route with the local flag adds a second clearing pass before it.
// Issue: one item at a time, limited by the single read port that visits every entry once per item;
//   busy stays high until the item's result is decided, and start is taken only while idle.
// Reset: synchronous rst_n empties the table at once (allocation flags cleared); no clearing pass.
// Results show for one cycle on out_strobe; the receiver cannot stall.
module token_route_table_unit import trt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [TOKEN_W-1:0] in_token,
  input  logic [LINK_W-1:0]  in_link_id,
  input  logic               in_local_flag,
  output logic               out_strobe,
  output logic [2:0]         out_status,
  output logic [LINK_W-1:0]  out_link_out
);

  mem_rd_t mem_rd;
  mem_wr_t mem_wr;
  entry_t  rd_data;
  res_t    res;

  logic              out_strobe_r;
  logic [2:0]        out_status_r;
  logic [LINK_W-1:0] out_link_out_r;

  trt_mem u_mem (
    .clk     (clk),
    .mem_rd  (mem_rd),
    .mem_wr  (mem_wr),
    .rd_data (rd_data)
  );

  trt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_command    (in_command),
    .in_token      (in_token),
    .in_link_id    (in_link_id),
    .in_local_flag (in_local_flag),
    .busy          (busy),
    .mem_rd        (mem_rd),
    .mem_wr        (mem_wr),
    .rd_data       (rd_data),
    .res           (res)
  );

  // Hold each result for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res.vld;
    end
    if (res.vld) begin
      out_status_r   <= res.status;
      out_link_out_r <= res.link;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_status   = out_status_r;
  assign out_link_out = out_link_out_r;

endmodule

>>> sv/trt_mem.sv
// Route entry memory: one write port, one registered read port.
module trt_mem import trt_pkg::*; (
  input  logic    clk,
  input  mem_rd_t mem_rd,
  input  mem_wr_t mem_wr,
  output entry_t  rd_data
);

  entry_t mem [ROUTE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[mem_wr.addr] <= mem_wr.data;
    end
    if (mem_rd.en) begin
      rd_data_r <= mem[mem_rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/trt_ctrl.sv
// Sequencer: scans the entry memory, decides the result and writes entries back.
`include "token_route_table_unit_assert.svh"

module trt_ctrl import trt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_command,
  input  logic [TOKEN_W-1:0] in_token,
  input  logic [LINK_W-1:0]  in_link_id,
  input  logic               in_local_flag,
  output logic               busy,
  output mem_rd_t            mem_rd,
  output mem_wr_t            mem_wr,
  input  entry_t             rd_data,
  output res_t               res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_DRAIN,
    S_DECIDE,
    S_CLEAR,
    S_CLEAR_DRAIN,
    S_FINISH
  } state_t;

  state_t                   state_r;
  logic                     cmd_r;
  logic [TOKEN_W-1:0]       tok_r;
  logic [LINK_W-1:0]        link_r;
  logic                     loc_r;
  logic [IDX_W-1:0]         rd_idx_r;
  logic                     cmp_vld_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic [ROUTE_ENTRIES-1:0] alloc_r;
  logic                     hit_r;
  logic [LINK_W-1:0]        hit_link_r;
  logic                     hit_loc_r;
  logic                     reuse_vld_r;
  logic [IDX_W-1:0]         reuse_idx_r;
  logic                     fresh_vld_r;
  logic [IDX_W-1:0]         fresh_idx_r;
  logic [IDX_W-1:0]         slot_r;

  logic             issuing;
  logic             cmp_alloc;
  logic             cmp_match;
  logic             link_hit;
  logic             cmp_free;
  logic             scan_phase;
  logic             scan_stage;
  logic             clr_stage;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_sel;
  logic [IDX_W-1:0] ins_idx;
  logic             ins_now;
  entry_t           new_entry;
  logic             route_res;
  logic             ins_res;

  assign issuing    = (state_r == S_SCAN) || (state_r == S_CLEAR);
  assign cmp_alloc  = alloc_r[cmp_idx_r];
  assign cmp_match  = cmp_alloc && (rd_data.tok == tok_r);
  assign link_hit   = (rd_data.link == link_r);
  // Entry is free for reuse as it will stand after the clearing pass.
  assign cmp_free   = cmp_alloc && ((rd_data.link == '0) || (loc_r && link_hit));
  assign scan_phase = (state_r == S_SCAN) || (state_r == S_SCAN_DRAIN);
  assign scan_stage = cmp_vld_r && scan_phase;
  assign clr_stage  = cmp_vld_r && ((state_r == S_CLEAR) || (state_r == S_CLEAR_DRAIN));
  assign slot_ok    = reuse_vld_r || fresh_vld_r;
  assign slot_sel   = reuse_vld_r ? reuse_idx_r : fresh_idx_r;
  assign ins_idx    = (state_r == S_FINISH) ? slot_r : slot_sel;
  assign ins_now    = ((state_r == S_DECIDE) && (cmd_r == CMD_INSERT) && !hit_r
                       && slot_ok && !loc_r) || (state_r == S_FINISH);
  assign new_entry  = '{tok: tok_r, link: link_r, loc: loc_r};

  assign busy = (state_r != S_IDLE);

  assign mem_rd.en   = issuing;
  assign mem_rd.addr = rd_idx_r;

  // Clearing writes land in the cycle after their read, so each read sees an untouched entry.
  always_comb begin
    if (clr_stage && cmp_alloc && link_hit) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = cmp_idx_r;
      mem_wr.data = '{tok: rd_data.tok, link: '0, loc: rd_data.loc};
    end else begin
      mem_wr.en   = ins_now;
      mem_wr.addr = ins_idx;
      mem_wr.data = new_entry;
    end
  end

  always_comb begin
    res.vld    = 1'b0;
    res.status = ST_NOROUTE;
    res.link   = '0;
    if (state_r == S_DECIDE) begin
      if (cmd_r == CMD_LOOKUP) begin
        res.vld = 1'b1;
        if (hit_r && (hit_link_r != '0)) begin
          res.status = hit_loc_r ? ST_LOCAL : ST_FORWARD;
          res.link   = hit_link_r;
        end
      end else begin
        priority if (hit_r) begin
          res.vld    = 1'b1;
          res.status = ST_PRESENT;
        end else if (!slot_ok) begin
          res.vld    = 1'b1;
          res.status = ST_FULL;
        end else if (!loc_r) begin
          res.vld    = 1'b1;
          res.status = ST_INSERTED;
        end else begin
          // Local insert: report after the clearing pass.
          res.vld    = 1'b0;
        end
      end
    end else if (state_r == S_FINISH) begin
      res.vld    = 1'b1;
      res.status = ST_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cmp_vld_r <= 1'b0;
      alloc_r   <= '0;
    end else begin
      cmp_vld_r <= issuing;
      cmp_idx_r <= rd_idx_r;
      if (ins_now) begin
        alloc_r[ins_idx] <= 1'b1;
      end
      // Keep the first match, the first reusable entry and the first unallocated entry.
      if (scan_stage) begin
        if (cmp_match && !hit_r) begin
          hit_r      <= 1'b1;
          hit_link_r <= rd_data.link;
          hit_loc_r  <= rd_data.loc;
        end
        if (cmp_free && !reuse_vld_r) begin
          reuse_vld_r <= 1'b1;
          reuse_idx_r <= cmp_idx_r;
        end
        if (!cmp_alloc && !fresh_vld_r) begin
          fresh_vld_r <= 1'b1;
          fresh_idx_r <= cmp_idx_r;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r       <= in_command;
            tok_r       <= in_token;
            link_r      <= in_link_id;
            loc_r       <= in_local_flag;
            rd_idx_r    <= '0;
            hit_r       <= 1'b0;
            reuse_vld_r <= 1'b0;
            fresh_vld_r <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r == LAST_IDX) begin
            state_r <= S_SCAN_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
        end
        S_SCAN_DRAIN: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if ((cmd_r == CMD_INSERT) && !hit_r && slot_ok && loc_r) begin
            slot_r   <= slot_sel;
            rd_idx_r <= '0;
            state_r  <= S_CLEAR;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_CLEAR: begin
          if (rd_idx_r == LAST_IDX) begin
            state_r <= S_CLEAR_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
        end
        S_CLEAR_DRAIN: begin
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign route_res = res.vld && ((res.status == ST_LOCAL) || (res.status == ST_FORWARD));
  assign ins_res   = res.vld && (res.status == ST_INSERTED);

  `TRT_ASSERT_NOW(a_scan_no_write, clk, rst_n, scan_phase, !mem_wr.en)
  `TRT_ASSERT_NOW(a_full_all_alloc, clk, rst_n, res.vld && (res.status == ST_FULL), &alloc_r)
  `TRT_ASSERT_NOW(a_route_has_link, clk, rst_n, route_res, res.link != '0)
  `TRT_ASSERT_NEXT(a_insert_allocs, clk, rst_n, ins_res, alloc_r[$past(ins_idx)])

endmodule
